[design/vcf_genotype_dosage_parser_defines.svh]
// Assertion macros used by the checker file.
`ifndef VCF_GENOTYPE_DOSAGE_PARSER_DEFINES_SVH
`define VCF_GENOTYPE_DOSAGE_PARSER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define VGD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[design/vgd_pkg.sv]
// Package with the payload types, status codes and parser constants.
package vgd_pkg;
   localparam int MaxAllelesDefault = 255;
   localparam int MaxSamplesDefault = 65535;
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } req_word_type;

   typedef struct packed {
      logic [15:0] sample_index;
      logic [1:0]  dosage;
      logic [2:0]  line_status;
      logic        last_in_line;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SKIP     = 3'd1,
      ST_BAD      = 3'd2,
      ST_NEG      = 3'd3,
      ST_RANGE    = 3'd4,
      ST_FEWER    = 3'd5,
      ST_MORE     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_LEAD_FIRST = 3'd0,
      PH_LEAD       = 3'd1,
      PH_WS         = 3'd2,
      PH_SIGN_POS   = 3'd3,
      PH_SIGN_NEG   = 3'd4,
      PH_DIG_POS    = 3'd5,
      PH_DIG_NEG    = 3'd6,
      PH_SKIP       = 3'd7
   } phase_type;

   // Byte class computed by the front end.
   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
      logic       is_tab;
      logic       is_digit;
      logic       is_sep;
      logic       is_colon;
      logic       is_ws;
      logic       is_base;
      logic       is_comma;
      logic       is_dot;
      logic       is_plus;
      logic       is_minus;
   } class_word_type;

   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChBar   = 8'h7C;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChComma = 8'h2C;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChSpace = 8'h20;

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h23;
         3'd1: c = 8'h43;
         3'd2: c = 8'h48;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4F;
         3'd5: c = 8'h4D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction
endpackage

[design/vgd_front.sv]
// Front end: takes input words, classifies each byte and registers the class word.
module vgd_front
   import vgd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_word_type   req_word,
   output logic           cls_valid,
   input  logic           cls_stall,
   output class_word_type cls_word
);
   logic           valid_ff, valid_in;
   class_word_type word_ff, word_in;
   logic [7:0]     c;

   assign c = req_word.text_byte;
   assign req_stall = valid_ff && cls_stall;

   // Classification of the incoming byte.
   always_comb begin
      word_in.ch       = c;
      word_in.line_end = req_word.line_end;
      word_in.is_tab   = (c == ChTab);
      word_in.is_digit = (c >= 8'h30) && (c <= 8'h39);
      word_in.is_sep   = (c == ChBar) || (c == ChSlash);
      word_in.is_colon = (c == ChColon);
      word_in.is_ws    = (c == ChSpace) || ((c >= 8'd9) && (c <= 8'd13));
      word_in.is_base  = (c == 8'h41) || (c == 8'h43) || (c == 8'h47) || (c == 8'h54) ||
                         (c == 8'h61) || (c == 8'h63) || (c == 8'h67) || (c == 8'h74);
      word_in.is_comma = (c == ChComma);
      word_in.is_dot   = (c == ChDot);
      word_in.is_plus  = (c == ChPlus);
      word_in.is_minus = (c == ChMinus);
      valid_in = req_stall ? valid_ff : req_valid;
   end

   // Output register of the front end.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!req_stall && req_valid) begin
         word_ff <= word_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_word  = word_ff;
endmodule

[design/vgd_queue.sv]
// Short queue between the front end and the back end.
module vgd_queue
   import vgd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  class_word_type in_word,
   output logic           out_valid,
   input  logic           out_stall,
   output class_word_type out_word
);
   localparam int AW = $clog2(QueueDepth);
   class_word_type    mem_ff [QueueDepth];
   logic [AW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_word  = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   // Pointer and count update.
   always_comb begin
      wp_in  = push ? AW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? AW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_word;
      end
   end
endmodule

[design/vgd_back.sv]
// Back end: runs the line parser on class words and registers the result word.
module vgd_back
   import vgd_pkg::*;
#(
   parameter int MAX_ALLELES = MaxAllelesDefault,
   parameter int MAX_SAMPLES = MaxSamplesDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           cfg_biallelic,
   input  logic [15:0]    cfg_samples,
   input  logic           cls_valid,
   output logic           cls_stall,
   input  class_word_type cls_word,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);
   // Parser state.
   logic        hdr_seen_ff, hdr_seen_in;
   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [3:0]  col_ff, col_in;
   logic [15:0] scnt_ff, scnt_in;
   logic [1:0]  single_ff, single_in;
   logic [7:0]  alleles_ff, alleles_in;
   logic        in_gt_ff, in_gt_in;
   logic [8:0]  acc_ff, acc_in;
   logic [2:0]  flags_ff, flags_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic        dmiss_ff, dmiss_in;
   logic        drop_ff, drop_in;
   logic        has_ch_ff, has_ch_in;
   logic [2:0]  serr_ff, serr_in;
   logic        ovalid_ff, ovalid_in;
   rsp_word_type oword_ff, oword_in;

   logic        take, emit;
   rsp_word_type ew;
   logic [16:0] eff;
   logic        last;
   logic [12:0] mul;
   logic [7:0]  max_a;

   assign cls_stall = ovalid_ff && rsp_stall;
   assign take = cls_valid && !cls_stall;
   assign max_a = 8'(MAX_ALLELES);
   assign mul = {4'd0, acc_ff} * 13'd10 + {9'd0, cls_word.ch[3:0]};

   // Effective sample count and last-sample test.
   always_comb begin
      eff = {1'b0, cfg_samples};
      if (eff == '0) eff = 17'd1;
      if (eff > 17'(MAX_SAMPLES)) eff = 17'(MAX_SAMPLES);
      last = ({1'b0, scnt_ff} + 17'd1) >= eff;
   end

   // Next-state logic of the parser.
   always_comb begin
      logic       le, skip, neg;
      phase_type  ph;
      logic [2:0] e;
      logic [1:0] dos;
      hdr_seen_in = hdr_seen_ff; hdr_pos_in = hdr_pos_ff; col_in = col_ff;
      scnt_in = scnt_ff; single_in = single_ff; alleles_in = alleles_ff;
      in_gt_in = in_gt_ff; acc_in = acc_ff; flags_in = flags_ff; dcnt_in = dcnt_ff;
      dmiss_in = dmiss_ff; drop_in = drop_ff; has_ch_in = has_ch_ff; serr_in = serr_ff;
      emit = 1'b0; ew = '0;
      le = cls_word.line_end; skip = 1'b0; neg = 1'b0; ph = phase_type'(flags_ff);
      e = 3'd0; dos = 2'd0;
      if (!hdr_seen_ff) begin
         if (le) begin
            if (hdr_pos_ff == 3'd6) hdr_seen_in = 1'b1;
            hdr_pos_in = 3'd0;
         end else if (hdr_pos_ff < 3'd6) begin
            hdr_pos_in = (cls_word.ch == header_char(hdr_pos_ff)) ? hdr_pos_ff + 3'd1 : 3'd7;
         end
      end else if (drop_ff) begin
         if (le) begin
            col_in = '0; scnt_in = '0; single_in = 2'b11; alleles_in = 8'd1; drop_in = 1'b0;
            in_gt_in = 1'b1; acc_in = '0; flags_in = PH_LEAD_FIRST; dcnt_in = '0;
            dmiss_in = 1'b0; has_ch_in = 1'b0; serr_in = '0;
         end
      end else if (!le && !cls_word.is_tab) begin
         has_ch_in = 1'b1;
         if (col_ff < 4'd9) begin
            // Fixed column character.
            if (col_ff == 4'd3 && acc_ff == '0) single_in[0] = cls_word.is_base;
            if (col_ff == 4'd4) begin
               if ((acc_ff == '0 || flags_ff[0]) && alleles_ff < max_a)
                  alleles_in = alleles_ff + 8'd1;
               flags_in[0] = cls_word.is_comma;
               if (acc_ff == '0) begin
                  single_in[1] = cls_word.is_base;
                  flags_in[1] = cls_word.is_dot;
               end
            end
            if (acc_ff < 9'd2) acc_in = acc_ff + 9'd1;
         end else if (in_gt_ff && serr_ff == '0) begin
            // Genotype character.
            if (cls_word.is_colon) begin
               if (ph == PH_WS || ph == PH_SIGN_POS || ph == PH_SIGN_NEG) serr_in = ST_BAD;
               else if (ph == PH_DIG_POS || ph == PH_DIG_NEG) begin
                  if (ph == PH_DIG_NEG && acc_ff != '0) serr_in = ST_NEG;
                  else if (acc_ff >= {1'b0, alleles_ff}) serr_in = ST_RANGE;
                  else if (acc_ff == '0 && dcnt_ff < 2'd2) dcnt_in = dcnt_ff + 2'd1;
               end
               in_gt_in = 1'b0;
            end else begin
               unique case (ph)
                  PH_LEAD_FIRST, PH_LEAD, PH_WS: begin
                     if (ph == PH_LEAD && cls_word.is_ws) flags_in = PH_WS;
                     else if (!cls_word.is_ws || ph == PH_LEAD) begin
                        if (cls_word.is_digit) begin
                           acc_in = {5'd0, cls_word.ch[3:0]}; flags_in = PH_DIG_POS;
                        end else if (cls_word.is_plus) flags_in = PH_SIGN_POS;
                        else if (cls_word.is_minus) flags_in = PH_SIGN_NEG;
                        else if (cls_word.is_dot && ph != PH_WS) begin
                           dmiss_in = 1'b1; flags_in = PH_SKIP;
                        end else serr_in = ST_BAD;
                     end
                  end
                  PH_SIGN_POS, PH_SIGN_NEG: begin
                     if (cls_word.is_digit) begin
                        acc_in = {5'd0, cls_word.ch[3:0]};
                        flags_in = (ph == PH_SIGN_NEG) ? PH_DIG_NEG : PH_DIG_POS;
                     end else serr_in = ST_BAD;
                  end
                  PH_DIG_POS, PH_DIG_NEG: begin
                     if (cls_word.is_digit) acc_in = (mul > 13'd511) ? 9'd511 : mul[8:0];
                     else begin
                        if (ph == PH_DIG_NEG && acc_ff != '0) serr_in = ST_NEG;
                        else if (acc_ff >= {1'b0, alleles_ff}) serr_in = ST_RANGE;
                        else if (acc_ff == '0 && dcnt_ff < 2'd2) dcnt_in = dcnt_ff + 2'd1;
                        flags_in = cls_word.is_sep ? PH_LEAD : PH_SKIP;
                     end
                  end
                  default: if (cls_word.is_sep) flags_in = PH_LEAD;
               endcase
            end
         end
      end else if (col_ff < 4'd9) begin
         // Fixed column closed by tab or line end.
         if (col_ff == 4'd3 && acc_ff != 9'd1) single_in[0] = 1'b0;
         if (col_ff == 4'd4) begin
            if (acc_ff != 9'd1) single_in[1] = 1'b0;
            if (acc_ff == 9'd1 && flags_ff[1]) alleles_in = 8'd1;
            skip = cfg_biallelic && (single_in != 2'b11);
         end
         acc_in = '0; flags_in = '0;
         if (le && !has_ch_ff) begin
            emit = 1'b1; ew = '{16'd0, 2'd3, ST_FEWER, 1'b1};
         end else if (skip) begin
            emit = 1'b1; ew = '{16'd0, 2'd3, ST_SKIP, 1'b1};
            if (!le) drop_in = 1'b1;
         end else if (le) begin
            emit = 1'b1; ew = '{16'd0, 2'd3, ST_FEWER, 1'b1};
         end else begin
            col_in = col_ff + 4'd1;
            if (col_ff == 4'd8) scnt_in = '0;
            in_gt_in = 1'b1; dcnt_in = '0; dmiss_in = 1'b0; has_ch_in = 1'b0; serr_in = '0;
         end
         if (le) begin
            col_in = '0; scnt_in = '0; single_in = 2'b11; alleles_in = 8'd1; drop_in = 1'b0;
            in_gt_in = 1'b1; acc_in = '0; flags_in = PH_LEAD_FIRST; dcnt_in = '0;
            dmiss_in = 1'b0; has_ch_in = 1'b0; serr_in = '0;
         end
      end else begin
         // Sample column closed by tab or line end.
         e = serr_ff; dos = dcnt_ff;
         if (in_gt_ff && serr_ff == '0) begin
            if (ph == PH_WS || ph == PH_SIGN_POS || ph == PH_SIGN_NEG) e = ST_BAD;
            else if (ph == PH_DIG_POS || ph == PH_DIG_NEG) begin
               neg = (ph == PH_DIG_NEG);
               if (neg && acc_ff != '0) e = ST_NEG;
               else if (acc_ff >= {1'b0, alleles_ff}) e = ST_RANGE;
               else if (acc_ff == '0 && dcnt_ff < 2'd2) dos = dcnt_ff + 2'd1;
            end
         end
         emit = 1'b1;
         if (le && !has_ch_ff) ew = '{scnt_ff, 2'd3, ST_FEWER, 1'b1};
         else if (!le && last) begin
            ew = '{scnt_ff, 2'd3, ST_MORE, 1'b1}; drop_in = 1'b1;
         end else if (e != 3'd0) begin
            ew = '{scnt_ff, 2'd3, e, 1'b1};
            if (!le) drop_in = 1'b1;
         end else if (le) begin
            if (last) ew = '{scnt_ff, dmiss_ff ? 2'd3 : dos, ST_OK, 1'b1};
            else ew = '{16'(scnt_ff + 16'd1), 2'd3, ST_FEWER, 1'b1};
         end else begin
            ew = '{scnt_ff, dmiss_ff ? 2'd3 : dos, ST_OK, 1'b0};
            scnt_in = scnt_ff + 16'd1;
            in_gt_in = 1'b1; acc_in = '0; flags_in = PH_LEAD_FIRST; dcnt_in = '0;
            dmiss_in = 1'b0; has_ch_in = 1'b0; serr_in = '0;
         end
         if (le) begin
            col_in = '0; scnt_in = '0; single_in = 2'b11; alleles_in = 8'd1; drop_in = 1'b0;
            in_gt_in = 1'b1; acc_in = '0; flags_in = PH_LEAD_FIRST; dcnt_in = '0;
            dmiss_in = 1'b0; has_ch_in = 1'b0; serr_in = '0;
         end
      end
   end

   // Result register.
   always_comb begin
      ovalid_in = ovalid_ff && rsp_stall;
      oword_in  = oword_ff;
      if (take && emit) begin
         ovalid_in = 1'b1;
         oword_in  = ew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_seen_ff <= 1'b0; hdr_pos_ff <= '0; col_ff <= '0; scnt_ff <= '0;
         single_ff <= 2'b11; alleles_ff <= 8'd1; in_gt_ff <= 1'b1; acc_ff <= '0;
         flags_ff <= '0; dcnt_ff <= '0; dmiss_ff <= 1'b0; drop_ff <= 1'b0;
         has_ch_ff <= 1'b0; serr_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            hdr_seen_ff <= hdr_seen_in; hdr_pos_ff <= hdr_pos_in; col_ff <= col_in;
            scnt_ff <= scnt_in; single_ff <= single_in; alleles_ff <= alleles_in;
            in_gt_ff <= in_gt_in; acc_ff <= acc_in; flags_ff <= flags_in;
            dcnt_ff <= dcnt_in; dmiss_ff <= dmiss_in; drop_ff <= drop_in;
            has_ch_ff <= has_ch_in; serr_ff <= serr_in;
         end
         ovalid_ff <= ovalid_in;
      end
      oword_ff <= oword_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_word  = oword_ff;
endmodule

[design/vcf_genotype_dosage_parser.sv]
// Top level of the VCF genotype dosage parser.
// Takes one text byte or line-end word per clock while not stalled and gives one dosage
// word for each sample column, or one status word when a line is skipped or malformed.
// A word passes the classifier register, a two-entry queue and the parser register, and
// a result word holds in the parser register while the receiver stalls; the parser
// updates once per cycle when it takes a word, which sets a sustained rate of one input
// word per clock while no stall holds the flow. Registers: 0 biallelic_only at byte 0,
// 1 sample_count at byte 4; write them only while the block is idle.
module vcf_genotype_dosage_parser
   import vgd_pkg::*;
#(
   parameter int MAX_ALLELES = MaxAllelesDefault,
   parameter int MAX_SAMPLES = MaxSamplesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam logic [2:0] AddrBiallelic = 3'd0;
   localparam logic [2:0] AddrSamples   = 3'd4;

   logic           bi_ff, bi_in;
   logic [15:0]    sc_ff, sc_in;
   logic           f_valid, f_stall, q_valid, q_stall;
   class_word_type f_word, q_word;

   // Configuration registers.
   assign csr_pready = 1'b1;
   always_comb begin
      bi_in = bi_ff; sc_in = sc_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == AddrBiallelic) bi_in = csr_pwdata[0];
         if (csr_paddr == AddrSamples) sc_in = csr_pwdata[15:0];
      end
      csr_prdata = '0;
      if (csr_paddr == AddrBiallelic) csr_prdata = {31'd0, bi_ff};
      else if (csr_paddr == AddrSamples) csr_prdata = {16'd0, sc_ff};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         bi_ff <= 1'b0; sc_ff <= 16'd1;
      end else begin
         bi_ff <= bi_in; sc_ff <= sc_in;
      end
   end

   vgd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .cls_valid(f_valid), .cls_stall(f_stall), .cls_word(f_word)
   );
   vgd_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_word(f_word),
      .out_valid(q_valid), .out_stall(q_stall), .out_word(q_word)
   );
   vgd_back #(.MAX_ALLELES(MAX_ALLELES), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock, .reset, .cfg_biallelic(bi_ff), .cfg_samples(sc_ff),
      .cls_valid(q_valid), .cls_stall(q_stall), .cls_word(q_word),
      .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

[design/vgd_checker.sv]
// Port checker for the parser, bound to the top level.
`include "vcf_genotype_dosage_parser_defines.svh"
module vgd_checker
   import vgd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);
   // A stalled result word holds.
   `VGD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   // Error results always carry the missing dosage and close the line.
   `VGD_ASSERT_IMP(a_err, clock, reset, rsp_valid && rsp_word.line_status != ST_OK, rsp_word.dosage == 2'd3 && rsp_word.last_in_line)
   // Status codes stay within the defined set.
   `VGD_ASSERT_IMP(a_code, clock, reset, rsp_valid, rsp_word.line_status != 3'd7)
endmodule

bind vcf_genotype_dosage_parser vgd_checker u_vgd_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_word
);

[sim/vcf_genotype_dosage_parser_tb.sv]
// Self-checking testbench for the VCF genotype dosage parser.
module vcf_genotype_dosage_parser_tb;
   import vgd_pkg::*;

   localparam int ClockPeriod = 20;
   localparam int IdleLimit = 3000;
   localparam int DrainCycles = 12;
   localparam int BurstCycles = 120;
   localparam logic [2:0] RegBiallelic = 3'd0;
   localparam logic [2:0] RegSampleCount = 3'd4;
   localparam string HeaderText = "#CHROM";
   localparam logic [7:0] ChZero = 8'h30;
   localparam logic [7:0] ChNine = 8'h39;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   vcf_genotype_dosage_parser u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Words waiting to be sent and dosage words waiting to arrive.
   req_word_type text_q[$];
   rsp_word_type dosage_q[$];
   int failures = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;
   int burst_left = 0;
   bit burst_done = 0;
   bit burst_go;
   bit tx_quiet;
   bit rx_quiet;

   // Parser state mirrored by the predictor.
   bit          cfg_biallelic;
   logic [15:0] cfg_samples;
   bit          hdr_seen;
   logic [2:0]  hdr_pos;
   logic [3:0]  col;
   logic [15:0] smp;
   logic [1:0]  single_base;
   logic [7:0]  n_alleles;
   bit          in_gt;
   logic [8:0]  acc;
   logic [1:0]  fix_flags;
   phase_type   ph;
   logic [1:0]  ref_count;
   bit          missing;
   bit          drop;
   bit          has_char;
   logic [2:0]  cell_err;

   function automatic bit is_base(input logic [7:0] c);
      return c inside {"A", "C", "G", "T", "a", "c", "g", "t"};
   endfunction

   function automatic bit is_ws(input logic [7:0] c);
      return c == ChSpace || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void cell_clear();
      in_gt = 1;
      acc = 0;
      ph = PH_LEAD_FIRST;
      ref_count = 0;
      missing = 0;
      has_char = 0;
      cell_err = ST_OK;
   endfunction

   function automatic void line_clear();
      col = 0;
      smp = 0;
      single_base = 2'b11;
      n_alleles = 1;
      drop = 0;
      fix_flags = 0;
      cell_clear();
   endfunction

   function automatic void eval_code(input bit neg);
      if (neg && acc != 0) cell_err = ST_NEG;
      else if (acc >= n_alleles) cell_err = ST_RANGE;
      else if (acc == 0 && ref_count < 2) ref_count++;
   endfunction

   function automatic void code_start(input logic [7:0] c, input bit allow_dot);
      if (c >= ChZero && c <= ChNine) begin
         acc = 9'(c - ChZero);
         ph = PH_DIG_POS;
      end else if (c == ChPlus) begin
         ph = PH_SIGN_POS;
      end else if (c == ChMinus) begin
         ph = PH_SIGN_NEG;
      end else if (c == ChDot && allow_dot) begin
         missing = 1;
         ph = PH_SKIP;
      end else begin
         cell_err = ST_BAD;
      end
   endfunction

   function automatic void gt_close();
      if (ph inside {PH_WS, PH_SIGN_POS, PH_SIGN_NEG}) cell_err = ST_BAD;
      else if (ph inside {PH_DIG_POS, PH_DIG_NEG}) eval_code(ph == PH_DIG_NEG);
      in_gt = 0;
   endfunction

   function automatic rsp_word_type make_word(input logic [15:0] idx, input logic [1:0] dos,
                                              input logic [2:0] st, input bit last);
      rsp_word_type r;
      r.sample_index = idx;
      r.dosage = dos;
      r.line_status = st;
      r.last_in_line = last;
      return r;
   endfunction

   // Advances the parser by one word; returns 1 when a dosage word results.
   function automatic bit predict_dosage(input req_word_type w, output rsp_word_type r);
      logic [7:0]  c;
      logic [15:0] sc;
      logic [16:0] eff;
      bit          le;
      bit          last;
      bit          skip;
      bit          sep;
      bit          dig;
      int          v;
      logic [1:0]  dos;
      c = w.text_byte;
      le = w.line_end;
      sc = smp;
      r = '0;
      if (!hdr_seen) begin
         if (le) begin
            if (hdr_pos == 6) hdr_seen = 1;
            hdr_pos = 0;
         end else if (hdr_pos < 6) begin
            hdr_pos = (c == HeaderText[hdr_pos]) ? hdr_pos + 3'd1 : 3'd7;
         end
         return 0;
      end
      if (drop) begin
         if (le) line_clear();
         return 0;
      end
      // An ordinary character inside a column.
      if (!le && c != ChTab) begin
         has_char = 1;
         if (col < 9) begin
            if (col == 3 && acc == 0) single_base[0] = is_base(c);
            if (col == 4) begin
               if ((acc == 0 || fix_flags[0]) && n_alleles < 255) n_alleles++;
               fix_flags[0] = (c == ChComma);
               if (acc == 0) begin
                  single_base[1] = is_base(c);
                  fix_flags[1] = (c == ChDot);
               end
            end
            if (acc < 2) acc++;
         end else if (in_gt && cell_err == ST_OK) begin
            sep = (c == ChBar || c == ChSlash);
            dig = (c >= ChZero && c <= ChNine);
            if (c == ChColon) begin
               gt_close();
            end else begin
               case (ph)
                  PH_LEAD_FIRST: if (!is_ws(c)) code_start(c, 1);
                  PH_LEAD: begin
                     if (is_ws(c)) ph = PH_WS;
                     else code_start(c, 1);
                  end
                  PH_WS: if (!is_ws(c)) code_start(c, 0);
                  PH_SIGN_POS, PH_SIGN_NEG: begin
                     if (dig) begin
                        acc = 9'(c - ChZero);
                        ph = (ph == PH_SIGN_NEG) ? PH_DIG_NEG : PH_DIG_POS;
                     end else begin
                        cell_err = ST_BAD;
                     end
                  end
                  PH_DIG_POS, PH_DIG_NEG: begin
                     if (dig) begin
                        v = int'(acc) * 10 + int'(c - ChZero);
                        acc = (v > 511) ? 9'd511 : 9'(v);
                     end else begin
                        eval_code(ph == PH_DIG_NEG);
                        ph = sep ? PH_LEAD : PH_SKIP;
                     end
                  end
                  default: if (sep) ph = PH_LEAD;
               endcase
            end
         end
         return 0;
      end
      // A fixed column closes.
      if (col < 9) begin
         if (le && !has_char) begin
            line_clear();
            r = make_word(16'd0, 2'd3, ST_FEWER, 1'b1);
            return 1;
         end
         skip = 0;
         if (col == 3 && acc != 1) single_base[0] = 0;
         if (col == 4) begin
            if (acc != 1) single_base[1] = 0;
            if (acc == 1 && fix_flags[1]) n_alleles = 1;
            skip = cfg_biallelic && single_base != 2'b11;
         end
         acc = 0;
         fix_flags = 0;
         if (skip) begin
            if (le) line_clear();
            else drop = 1;
            r = make_word(16'd0, 2'd3, ST_SKIP, 1'b1);
            return 1;
         end
         if (le) begin
            line_clear();
            r = make_word(16'd0, 2'd3, ST_FEWER, 1'b1);
            return 1;
         end
         col++;
         if (col == 9) smp = 0;
         cell_clear();
         return 0;
      end
      // A sample column closes.
      eff = (cfg_samples == 0) ? 17'd1 : {1'b0, cfg_samples};
      last = ({1'b0, sc} + 17'd1) >= eff;
      if (le && !has_char) begin
         line_clear();
         r = make_word(sc, 2'd3, ST_FEWER, 1'b1);
         return 1;
      end
      if (!le && last) begin
         drop = 1;
         r = make_word(sc, 2'd3, ST_MORE, 1'b1);
         return 1;
      end
      if (in_gt && cell_err == ST_OK) gt_close();
      if (cell_err != ST_OK) begin
         r = make_word(sc, 2'd3, cell_err, 1'b1);
         if (le) line_clear();
         else drop = 1;
         return 1;
      end
      dos = missing ? 2'd3 : ref_count;
      if (le) begin
         line_clear();
         if (last) r = make_word(sc, dos, ST_OK, 1'b1);
         else r = make_word(sc + 16'd1, 2'd3, ST_FEWER, 1'b1);
         return 1;
      end
      smp = sc + 16'd1;
      cell_clear();
      r = make_word(sc, dos, ST_OK, 1'b0);
      return 1;
   endfunction

   // Clock generator.
   initial begin
      clock = 0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Sender: one word at a time from the pending queue, with a random gap after each unless tx_quiet is set.
   always @(posedge clock) begin
      bit next_valid;
      if (reset) begin
         req_valid <= 0;
         req_word <= '0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) next_valid = 0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (text_q.size() > 0) begin
               req_word <= text_q.pop_front();
               next_valid = 1;
               gap_left = tx_quiet ? 0 : $urandom_range(15);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: random stall per word unless rx_quiet is set, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = rx_quiet ? 0 : $urandom_range(15);
         if (burst_go && !burst_done) begin
            burst_done = 1;
            burst_left = BurstCycles;
         end
         if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Prediction on accepted text words and comparison of accepted dosage words.
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (predict_dosage(req_word, exp_word)) dosage_q = {dosage_q, exp_word};
         end
         if (rsp_valid && !rsp_stall) begin
            if (dosage_q.size() == 0) begin
               $error("unexpected dosage word %p", rsp_word);
               failures++;
            end else begin
               exp_word = dosage_q.pop_front();
               if (rsp_word.sample_index !== exp_word.sample_index) begin
                  $error("sample_index: expected %0d, got %0d",
                         exp_word.sample_index, rsp_word.sample_index);
                  failures++;
               end
               if (rsp_word.dosage !== exp_word.dosage) begin
                  $error("dosage: expected %0d, got %0d", exp_word.dosage, rsp_word.dosage);
                  failures++;
               end
               if (rsp_word.line_status !== exp_word.line_status) begin
                  $error("line_status: expected %0d, got %0d",
                         exp_word.line_status, rsp_word.line_status);
                  failures++;
               end
               if (rsp_word.last_in_line !== exp_word.last_in_line) begin
                  $error("last_in_line: expected %0d, got %0d",
                         exp_word.last_in_line, rsp_word.last_in_line);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side and no register access.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("vcf_genotype_dosage_parser_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == RegBiallelic) cfg_biallelic = data[0];
      else cfg_samples = data[15:0];
   endtask

   task automatic push_byte(input logic [7:0] b, input bit le);
      req_word_type w;
      w.text_byte = b;
      w.line_end = le;
      text_q = {text_q, w};
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) push_byte(s[i], 0);
   endtask

   task automatic push_eol();
      push_byte(8'($urandom_range(255)), 1);
   endtask

   task automatic push_noise(input int n);
      repeat (n) push_byte(8'($urandom_range(255)), 0);
   endtask

   // Waits until every word has been sent and answered, then lets the pipeline settle.
   task automatic drain();
      while (text_q.size() > 0 || req_valid || dosage_q.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   string gt_pick[] = '{"0|0", "0/1", "1|0", "1/1", "./.", ".|0", ".", "0", "0|0|0",
                        "1/2", "2|0", "-1|0", "-0/0", "+1|0", " 0| 1", "0 |1", "0|1:35",
                        "x|0", "|0", "0|", "", "600|0", "0/a1", "1.|0", "0/.", "0|+",
                        "\r0/ 1", ". |0", "0| .", "+0", "0/0:12:x", "1|1"};
   string ref_pick[] = '{"A", "c", "g", "T", "A", "AT", "N", "", "."};
   string alt_pick[] = '{"G", "t", "C", "C,T", ".", "A,,G", ",", "<DEL>", "", "..", "a"};

   // One line: empty, noise, cut after ALT, or with n_cols random genotypes, or up to two more or fewer.
   task automatic push_line(input int n_cols);
      int kind;
      int cols;
      kind = $urandom_range(99);
      if (kind < 6) begin
         push_eol();
         return;
      end
      if (kind < 12) begin
         push_noise($urandom_range(12));
         push_eol();
         return;
      end
      push_text("chr1\t1042\trs7\t");
      push_text(ref_pick[$urandom_range(ref_pick.size() - 1)]);
      push_text("\t");
      push_text(alt_pick[$urandom_range(alt_pick.size() - 1)]);
      if (kind < 20) begin
         push_eol();
         return;
      end
      push_text("\t50\tPASS\t.\tGT:DP");
      cols = n_cols;
      if (kind < 32) cols = n_cols + $urandom_range(4) - 2;
      if (cols < 0) cols = 0;
      for (int i = 0; i < cols; i++) begin
         push_text("\t");
         if ($urandom_range(9) < 8) push_text(gt_pick[$urandom_range(gt_pick.size() - 1)]);
         else push_noise($urandom_range(4));
      end
      push_eol();
   endtask

   initial begin
      int phase_bi[] = '{1, 0, 1, 0, 1, 0, 1};
      int phase_sc[] = '{2, 3, 0, 65535, 1, 5, 4};
      int n_cols;
      reset = 1;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_go = 0;
      tx_quiet = 0;
      rx_quiet = 0;
      cfg_biallelic = 0;
      cfg_samples = 16'd1;
      hdr_seen = 0;
      hdr_pos = 0;
      line_clear();
      repeat (3) @(posedge clock);
      reset <= 0;

      // Preamble lines, a near miss of the header, then the header itself.
      push_text("##fileformat=VCFv4.2");
      push_eol();
      push_text("x#CHROM");
      push_eol();
      push_noise(6);
      push_eol();
      push_text("#CHROM\tPOS\tID\tREF\tALT\tQUAL\tFILTER\tINFO\tFORMAT\tS1");
      push_eol();
      // Directed data lines, mostly with one sample: ok, missing, error codes, column counts.
      push_text("1\t5\t.\tA\tG\t.\t.\t.\tGT\t0|0");
      push_eol();
      push_text("1\t6\t.\tA\tG,T\t.\t.\t.\tGT\t./1");
      push_eol();
      push_text("1\t7\t.\tA\tG\t.\t.\t.\tGT\t-1|0");
      push_eol();
      push_text("1\t8\t.\tA\t.\t.\t.\t.\tGT\t1|0");
      push_eol();
      push_text("1\t9\t.\tA\tG\t.\t.\t.\tGT\tq");
      push_eol();
      push_text("1\t9\t.\tA\tG\t.\t.\t.\tGT\t0\t1");
      push_eol();
      push_text("1\t9\t.\tA\tG\t.\t.\t.\tGT");
      push_eol();
      push_eol();
      drain();

      // Register settings in turn, each with random lines.
      foreach (phase_bi[p]) begin
         csr_write(RegBiallelic, phase_bi[p]);
         csr_write(RegSampleCount, phase_sc[p]);
         tx_quiet <= (p == 2);
         rx_quiet <= (p == 4);
         if (p == 2) burst_go <= 1;
         n_cols = (phase_sc[p] == 0) ? 1 : (phase_sc[p] > 6 ? 6 : phase_sc[p]);
         while (text_q.size() < 50) push_line(n_cols);
         drain();
      end

      if (failures == 0) begin
         $display("vcf_genotype_dosage_parser_tb: PASS");
      end else begin
         $display("vcf_genotype_dosage_parser_tb: FAIL");
      end
      $finish;
   end
endmodule
